// ===== design/bfsp_pkg.sv =====
// Package for the shortest-path block: payload word types, register indexes,
// sequencer states and sizing constants. Depends on nothing.
`default_nettype none

package bfsp_pkg;

    // Default sizing of the graph store.
    localparam int MAX_VERTICES_DEF = 32;
    localparam int MAX_EDGES_DEF    = 256;

    // Fixed field widths.
    localparam int VTX_W      = 5;
    localparam int WEIGHT_W   = 16;
    localparam int DIST_OUT_W = 32;
    localparam int CFG_NV_W   = 6;
    localparam int CFG_SRC_W  = 5;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int NV_W       = CFG_NV_W + 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_VERTICES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

    // Reset values of the registers.
    localparam logic [CFG_NV_W-1:0]  NUM_VERTICES_RST  = 6'd32;
    localparam logic [CFG_SRC_W-1:0] SOURCE_VERTEX_RST = 5'd0;

    // Reported distance limits; the upper one also marks an unreached vertex.
    localparam logic signed [DIST_OUT_W-1:0] DIST_MAX = 32'sh7fff_ffff;
    localparam logic signed [DIST_OUT_W-1:0] DIST_MIN = 32'sh8000_0000;

    // Input word: one directed weighted edge.
    typedef struct packed {
        logic [VTX_W-1:0]           edge_source;
        logic [VTX_W-1:0]           edge_dest;
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic                       last_edge;
    } edge_word_t;

    // Output word: one vertex distance, or the negative-cycle report.
    typedef struct packed {
        logic [VTX_W-1:0]             vertex_index;
        logic signed [DIST_OUT_W-1:0] distance;
        logic                         reachable;
        logic                         negative_cycle;
        logic                         edge_dropped;
        logic                         last_result;
    } result_word_t;

    // Edge as held in the edge memory.
    typedef struct packed {
        logic [VTX_W-1:0]    src;
        logic [VTX_W-1:0]    dst;
        logic [WEIGHT_W-1:0] weight;
    } edge_rec_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_INIT,
        S_FETCH,
        S_DREAD,
        S_RELAX,
        S_ORD,
        S_OLOAD,
        S_OWAIT
    } state_t;

endpackage

`default_nettype wire

// ===== design/bellman_ford_shortest_paths.sv =====
// Top level of the single-source shortest-path block: edge memory, distance
// memories and the relaxation sequencer. Depends on bfsp_pkg and bfsp_ram.
//
//   channel   | handshake                  | word
//   ----------+----------------------------+------------------------------
//   edge      | edge_valid / edge_ready    | edge_word   (edge_word_t)
//   result    | result_valid / result_ready| result_word (result_word_t)
//   config    | cfg_wr_en, cfg_index       | cfg_wdata   (write only)
//
// Loading accepts one edge word per cycle. The word marked last starts a run:
// a set-up state, then up to V-1 relaxation passes and one check pass, each
// visiting S_FETCH, S_DREAD and, if usable, S_RELAX per edge, then S_FETCH to
// close it; one shared adder and comparator does every relaxation. A result
// takes S_ORD (distances only), S_OLOAD, then S_OWAIT until result_ready.
// No clearing pass follows reset; edge_ready is high only while loading.
`default_nettype none

module bellman_ford_shortest_paths
    import bfsp_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  edge_valid,
    output logic                       edge_ready,
    input  wire edge_word_t            edge_word,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_word_t               result_word,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int VTX_AW  = $clog2(MAX_VERTICES);
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
    // Wide enough for any distance that V-1 in-place passes can produce.
    localparam int DIST_W  = WEIGHT_W + $clog2(MAX_EDGES + 1) + $clog2(MAX_VERTICES + 1);
    localparam int SAT_W   = (DIST_W > DIST_OUT_W) ? DIST_W : DIST_OUT_W;
    localparam int ER_W    = $bits(edge_rec_t);

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(DIST_MAX);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(DIST_MIN);

    // Control registers.
    state_t                  state_reg, state_next;
    logic [CFG_NV_W-1:0]     num_vertices_reg, num_vertices_next;
    logic [CFG_SRC_W-1:0]    source_vertex_reg, source_vertex_next;
    logic [EDGE_CW-1:0]      edge_count_reg, edge_count_next;
    logic                    dropped_reg, dropped_next;
    logic [MAX_VERTICES-1:0] reached_reg, reached_next;
    logic [EDGE_CW-1:0]      j_reg, j_next;
    logic [NV_W-1:0]         pass_reg, pass_next;
    logic                    check_reg, check_next;
    logic                    changed_reg, changed_next;
    logic                    neg_reg, neg_next;
    logic [VTX_AW-1:0]       k_reg, k_next;
    logic                    out_valid_reg, out_valid_next;

    // Output payload register.
    result_word_t            out_word_reg, out_word_next;

    // Memory ports.
    logic                    er_wr_en, er_rd_en;
    edge_rec_t               er_wr_data, er_rd_data;
    logic [ER_W-1:0]         er_rd_raw;
    logic                    dm_wr_en, dm_rd_en_a, dm_rd_en_b;
    logic [VTX_AW-1:0]       dm_wr_addr, dm_rd_addr_a, dm_rd_addr_b;
    logic [DIST_W-1:0]       dm_wr_data, dm_rd_data_a, dm_rd_data_b;

    // Datapath signals.
    logic [NV_W-1:0]         nv_eff;
    logic                    in_fire, in_ok;
    logic [NV_W-1:0]         src_ext;
    logic [VTX_AW-1:0]       src_idx, u_idx, v_idx;
    logic                    edge_use;
    logic signed [DIST_W-1:0] du, dv, w_ext, cand;
    logic                    improve;
    logic signed [SAT_W-1:0] dist_ext;
    logic signed [DIST_OUT_W-1:0] dist_sat;
    logic                    last_vertex;

    // Effective vertex count: zero reads as one, large values saturate.
    always_comb
    begin
        if (num_vertices_reg == '0)
        begin
            nv_eff = NV_W'(1);
        end
        else if (NV_W'(num_vertices_reg) > NV_W'(MAX_VERTICES))
        begin
            nv_eff = NV_W'(MAX_VERTICES);
        end
        else
        begin
            nv_eff = NV_W'(num_vertices_reg);
        end
    end

    // Edge intake and acceptance test.
    assign edge_ready = (state_reg == S_LOAD);
    assign in_fire    = edge_valid && edge_ready;
    assign in_ok      = (NV_W'(edge_word.edge_source) < nv_eff)
                     && (NV_W'(edge_word.edge_dest) < nv_eff)
                     && (edge_count_reg < EDGE_CW'(MAX_EDGES));

    assign er_wr_data.src    = edge_word.edge_source;
    assign er_wr_data.dst    = edge_word.edge_dest;
    assign er_wr_data.weight = edge_word.edge_weight;
    assign er_wr_en          = in_fire && in_ok;
    assign er_rd_data        = edge_rec_t'(er_rd_raw);

    // Indexes of the source and of the current edge's ends.
    assign src_ext = NV_W'(source_vertex_reg);
    assign src_idx = VTX_AW'(source_vertex_reg);
    assign u_idx   = VTX_AW'(er_rd_data.src);
    assign v_idx   = VTX_AW'(er_rd_data.dst);

    // An edge takes part only if both ends are in use and its tail is reached.
    assign edge_use = (NV_W'(er_rd_data.src) < nv_eff)
                   && (NV_W'(er_rd_data.dst) < nv_eff)
                   && reached_reg[u_idx];

    // Shared relaxation unit: one add and one signed compare.
    assign du      = $signed(dm_rd_data_a);
    assign dv      = $signed(dm_rd_data_b);
    assign w_ext   = DIST_W'($signed(er_rd_data.weight));
    assign cand    = du + w_ext;
    assign improve = !reached_reg[v_idx] || (cand < dv);

    // Saturation of a reported distance to 32 bits.
    assign dist_ext = SAT_W'(du);
    always_comb
    begin
        if (dist_ext > SAT_HI)
        begin
            dist_sat = DIST_MAX;
        end
        else if (dist_ext < SAT_LO)
        begin
            dist_sat = DIST_MIN;
        end
        else
        begin
            dist_sat = $signed(dist_ext[DIST_OUT_W-1:0]);
        end
    end

    assign last_vertex = (NV_W'(k_reg) == (nv_eff - NV_W'(1)));

    // Memory read selection.
    assign er_rd_en     = (state_reg == S_FETCH) && (j_reg < edge_count_reg);
    assign dm_rd_en_a   = ((state_reg == S_DREAD) && edge_use) || (state_reg == S_ORD);
    assign dm_rd_en_b   = (state_reg == S_DREAD) && edge_use;
    assign dm_rd_addr_a = (state_reg == S_ORD) ? k_reg : u_idx;
    assign dm_rd_addr_b = v_idx;

    // Sequencer: next state, register updates and memory writes.
    always_comb
    begin
        state_next         = state_reg;
        num_vertices_next  = num_vertices_reg;
        source_vertex_next = source_vertex_reg;
        edge_count_next    = edge_count_reg;
        dropped_next       = dropped_reg;
        reached_next       = reached_reg;
        j_next             = j_reg;
        pass_next          = pass_reg;
        check_next         = check_reg;
        changed_next       = changed_reg;
        neg_next           = neg_reg;
        k_next             = k_reg;
        out_valid_next     = out_valid_reg;
        out_word_next      = out_word_reg;
        dm_wr_en           = 1'b0;
        dm_wr_addr         = v_idx;
        dm_wr_data         = cand;

        // User must keep configuration writes to idle; block does not check.
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NUM_VERTICES:  num_vertices_next  = cfg_wdata[CFG_NV_W-1:0];
                REG_SOURCE_VERTEX: source_vertex_next = cfg_wdata[CFG_SRC_W-1:0];
                default:           ;
            endcase
        end

        unique case (state_reg)
            // Store edges; the last one starts the run.
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (in_ok)
                    begin
                        edge_count_next = edge_count_reg + EDGE_CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (edge_word.last_edge)
                    begin
                        state_next = S_INIT;
                    end
                end
            end

            // Only the source starts reached, at distance zero.
            S_INIT:
            begin
                reached_next = '0;
                if (src_ext < nv_eff)
                begin
                    reached_next[src_idx] = 1'b1;
                    dm_wr_en   = 1'b1;
                    dm_wr_addr = src_idx;
                    dm_wr_data = '0;
                end
                j_next       = '0;
                pass_next    = NV_W'(1);
                changed_next = 1'b0;
                neg_next     = 1'b0;
                check_next   = (nv_eff == NV_W'(1));
                state_next   = S_FETCH;
            end

            // Read the next edge, or close the pass.
            S_FETCH:
            begin
                if (j_reg < edge_count_reg)
                begin
                    state_next = S_DREAD;
                end
                else if (check_reg)
                begin
                    neg_next   = changed_reg;
                    k_next     = '0;
                    state_next = changed_reg ? S_OLOAD : S_ORD;
                end
                else
                begin
                    j_next       = '0;
                    changed_next = 1'b0;
                    if (!changed_reg || (pass_reg == (nv_eff - NV_W'(1))))
                    begin
                        check_next = 1'b1;
                    end
                    else
                    begin
                        pass_next = pass_reg + NV_W'(1);
                    end
                end
            end

            // Fetch both end distances, or skip an edge that cannot relax.
            S_DREAD:
            begin
                if (edge_use)
                begin
                    state_next = S_RELAX;
                end
                else
                begin
                    j_next     = j_reg + EDGE_CW'(1);
                    state_next = S_FETCH;
                end
            end

            // Relax in place; the check pass only notes an improvement.
            S_RELAX:
            begin
                if (improve)
                begin
                    changed_next = 1'b1;
                    if (!check_reg)
                    begin
                        dm_wr_en            = 1'b1;
                        reached_next[v_idx] = 1'b1;
                    end
                end
                j_next     = j_reg + EDGE_CW'(1);
                state_next = S_FETCH;
            end

            // Read the distance of the vertex to report.
            S_ORD:
            begin
                state_next = S_OLOAD;
            end

            // Fill the output register.
            S_OLOAD:
            begin
                out_valid_next              = 1'b1;
                out_word_next.edge_dropped  = dropped_reg;
                if (neg_reg)
                begin
                    out_word_next.vertex_index   = '0;
                    out_word_next.distance       = '0;
                    out_word_next.reachable      = 1'b0;
                    out_word_next.negative_cycle = 1'b1;
                    out_word_next.last_result    = 1'b1;
                end
                else
                begin
                    out_word_next.vertex_index   = VTX_W'(k_reg);
                    out_word_next.reachable      = reached_reg[k_reg];
                    out_word_next.distance       = reached_reg[k_reg] ? dist_sat : DIST_MAX;
                    out_word_next.negative_cycle = 1'b0;
                    out_word_next.last_result    = last_vertex;
                end
                state_next = S_OWAIT;
            end

            // Hold the word until taken; the last one ends the run.
            S_OWAIT:
            begin
                if (result_ready)
                begin
                    out_valid_next = 1'b0;
                    if (neg_reg || last_vertex)
                    begin
                        edge_count_next = '0;
                        dropped_next    = 1'b0;
                        state_next      = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + VTX_AW'(1);
                        state_next = S_ORD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_LOAD;
            num_vertices_reg  <= NUM_VERTICES_RST;
            source_vertex_reg <= SOURCE_VERTEX_RST;
            edge_count_reg    <= '0;
            dropped_reg       <= 1'b0;
            reached_reg       <= '0;
            j_reg             <= '0;
            pass_reg          <= '0;
            check_reg         <= 1'b0;
            changed_reg       <= 1'b0;
            neg_reg           <= 1'b0;
            k_reg             <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            num_vertices_reg  <= num_vertices_next;
            source_vertex_reg <= source_vertex_next;
            edge_count_reg    <= edge_count_next;
            dropped_reg       <= dropped_next;
            reached_reg       <= reached_next;
            j_reg             <= j_next;
            pass_reg          <= pass_next;
            check_reg         <= check_next;
            changed_reg       <= changed_next;
            neg_reg           <= neg_next;
            k_reg             <= k_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    // Edge memory.
    bfsp_ram #(
        .WIDTH (ER_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (er_wr_en),
        .wr_addr (edge_count_reg[EDGE_AW-1:0]),
        .wr_data (er_wr_data),
        .rd_en   (er_rd_en),
        .rd_addr (j_reg[EDGE_AW-1:0]),
        .rd_data (er_rd_raw)
    );

    // Distance memory, tail-side read copy.
    bfsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_a (
        .clk     (clk),
        .wr_en   (dm_wr_en),
        .wr_addr (dm_wr_addr),
        .wr_data (dm_wr_data),
        .rd_en   (dm_rd_en_a),
        .rd_addr (dm_rd_addr_a),
        .rd_data (dm_rd_data_a)
    );

    // Distance memory, head-side read copy.
    bfsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_b (
        .clk     (clk),
        .wr_en   (dm_wr_en),
        .wr_addr (dm_wr_addr),
        .wr_data (dm_wr_data),
        .rd_en   (dm_rd_en_b),
        .rd_addr (dm_rd_addr_b),
        .rd_data (dm_rd_data_b)
    );

endmodule

`default_nettype wire

// ===== design/bfsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data word holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
